### sv/cpfv_pkg.sv
// Shared types, widths and the mod-11 check digit function for the CPF validator.
package cpfv_pkg;

  localparam int unsigned NUM_W      = 37;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 12;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // Reciprocal of 11 scaled by 2^RECIP_SHIFT, exact for sums below 2730
  localparam int unsigned RECIP_SHIFT = 14;
  localparam int unsigned RECIP_11    = 1490;
  localparam int unsigned MODULUS     = 11;

  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SUM_W-1:0]   sum_t;

  // Payload carried down the digit-conversion chain
  typedef struct packed {
    num_t num;
    bcd_t bcd;
  } dd_item_t;

  typedef struct packed {
    digit_t second_check;
    digit_t first_check;
    num_t   stored_number;
    logic   is_valid;
  } res_t;

  // r = s mod 11; check = 0 for r < 2, else 11 - r
  function automatic digit_t check_digit(input sum_t s);
    logic [SUM_W+10:0] prod;
    logic [6:0]        q;
    sum_t              q11;
    sum_t              r;
    prod = {11'd0, s} * (SUM_W + 11)'(RECIP_11);
    q    = prod[RECIP_SHIFT +: 7];
    q11  = SUM_W'({3'd0, q} * 10'(MODULUS));
    r    = s - q11;
    if (r < sum_t'(2)) begin
      check_digit = '0;
    end else begin
      check_digit = DIGIT_W'(sum_t'(MODULUS) - r);
    end
  endfunction

endpackage

### sv/cpfv_dd_cell.sv
// One shift-add-3 cell of the binary to BCD conversion chain.
module cpfv_dd_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               valid_i,
  input  cpfv_pkg::dd_item_t item_i,
  output logic               valid_o,
  output cpfv_pkg::dd_item_t item_o
);

  logic               valid_r;
  logic               valid_nxt;
  cpfv_pkg::dd_item_t item_r;
  cpfv_pkg::dd_item_t item_nxt;
  cpfv_pkg::bcd_t     adj;

  // add 3 to every digit of 5 or more, then shift in the next binary bit
  always_comb begin
    for (int j = 0; j < cpfv_pkg::NUM_DIGITS; j++) begin
      if (item_i.bcd[j*cpfv_pkg::DIGIT_W +: cpfv_pkg::DIGIT_W] >= cpfv_pkg::digit_t'(5)) begin
        adj[j*cpfv_pkg::DIGIT_W +: cpfv_pkg::DIGIT_W] =
          item_i.bcd[j*cpfv_pkg::DIGIT_W +: cpfv_pkg::DIGIT_W] + cpfv_pkg::digit_t'(3);
      end else begin
        adj[j*cpfv_pkg::DIGIT_W +: cpfv_pkg::DIGIT_W] =
          item_i.bcd[j*cpfv_pkg::DIGIT_W +: cpfv_pkg::DIGIT_W];
      end
    end
    item_nxt.num = item_i.num;
    item_nxt.bcd = {adj[cpfv_pkg::BCD_W-2:0], item_i.num[BIT_POS]};
    valid_nxt    = valid_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

### sv/cpfv_check.sv
// Weighted digit sums, mod-11 reduction and validity compare, three stages.
module cpfv_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               valid_i,
  input  cpfv_pkg::dd_item_t item_i,
  output logic               valid_o,
  output cpfv_pkg::res_t     res_o
);

  // stage 1: sums
  logic              s1_v_r;
  cpfv_pkg::sum_t    s1_sum1_r, s1_sum1_nxt;
  cpfv_pkg::sum_t    s1_sum2_r, s1_sum2_nxt;
  cpfv_pkg::digit_t  s1_tens_r;
  cpfv_pkg::digit_t  s1_units_r;
  logic              s1_big_r;
  cpfv_pkg::num_t    s1_num_r;
  // stage 2: first check digit
  logic              s2_v_r;
  cpfv_pkg::digit_t  s2_d1_r;
  cpfv_pkg::sum_t    s2_sum2_r;
  cpfv_pkg::digit_t  s2_tens_r;
  cpfv_pkg::digit_t  s2_units_r;
  logic              s2_big_r;
  cpfv_pkg::num_t    s2_num_r;
  // stage 3: result
  logic              s3_v_r;
  cpfv_pkg::res_t    s3_res_r, s3_res_nxt;
  cpfv_pkg::digit_t  d2;

  // base digits sit at decimal places 2..10; weight is the place (first) or place+1 (second)
  always_comb begin
    s1_sum1_nxt = '0;
    s1_sum2_nxt = '0;
    for (int j = 2; j <= 10; j++) begin
      s1_sum1_nxt = s1_sum1_nxt +
        cpfv_pkg::sum_t'(item_i.bcd[j*cpfv_pkg::DIGIT_W +: cpfv_pkg::DIGIT_W]) *
        cpfv_pkg::sum_t'(j);
      s1_sum2_nxt = s1_sum2_nxt +
        cpfv_pkg::sum_t'(item_i.bcd[j*cpfv_pkg::DIGIT_W +: cpfv_pkg::DIGIT_W]) *
        cpfv_pkg::sum_t'(j + 1);
    end
  end

  always_comb begin
    d2 = cpfv_pkg::check_digit(s2_sum2_r + {5'd0, s2_d1_r, 1'b0});
    s3_res_nxt.first_check  = s2_d1_r;
    s3_res_nxt.second_check = d2;
    s3_res_nxt.is_valid     = !s2_big_r && (s2_tens_r == s2_d1_r) && (s2_units_r == d2);
    s3_res_nxt.stored_number = s3_res_nxt.is_valid ? s2_num_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= valid_i;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum1_r  <= s1_sum1_nxt;
      s1_sum2_r  <= s1_sum2_nxt;
      s1_tens_r  <= item_i.bcd[cpfv_pkg::DIGIT_W +: cpfv_pkg::DIGIT_W];
      s1_units_r <= item_i.bcd[0 +: cpfv_pkg::DIGIT_W];
      s1_big_r   <= item_i.bcd[cpfv_pkg::BCD_W-1 -: cpfv_pkg::DIGIT_W] != '0;
      s1_num_r   <= item_i.num;
      s2_d1_r    <= cpfv_pkg::check_digit(s1_sum1_r);
      s2_sum2_r  <= s1_sum2_r;
      s2_tens_r  <= s1_tens_r;
      s2_units_r <= s1_units_r;
      s2_big_r   <= s1_big_r;
      s2_num_r   <= s1_num_r;
      s3_res_r   <= s3_res_nxt;
    end
  end

  assign valid_o = s3_v_r;
  assign res_o   = s3_res_r;

endmodule

### sv/cpf_check_digit_validator.sv
// Top level: BCD conversion chain, check digit stages and output skid.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | in_tdata: id_number
//  out_    | out | out_tvalid/out_tready | out_tdata: is_valid, stored_number,
//          |     |                     |   first_check, second_check
//
// One item per cycle while the skid register is empty. The item enters the first of
// 37 chain cells (one binary bit each) at the accepting edge, then passes three check
// stages and the output register.
// rst_n is synchronous and clears all valid flags; payload registers are not reset.
// The whole pipe stalls only while the skid register holds a result, so the
// block keeps accepting items while one finished result waits at the output.
module cpf_check_digit_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [36:0] id_number, [39:37] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [0] is_valid, [37:1] stored_number,
                                  // [41:38] first_check, [45:42] second_check, [47:46] zero
);

  localparam int unsigned NCELL = cpfv_pkg::NUM_W;

  logic               adv;
  logic               chain_v [0:NCELL];
  cpfv_pkg::dd_item_t chain_item [0:NCELL];
  logic               res_v;
  cpfv_pkg::res_t     res;
  logic               push;
  logic               out_v_r, out_v_nxt;
  cpfv_pkg::res_t     out_res_r, out_res_nxt;
  logic               skid_v_r, skid_v_nxt;
  cpfv_pkg::res_t     skid_res_r;

  assign adv       = !skid_v_r;
  assign in_tready = adv;

  assign chain_v[0]        = in_tvalid;
  assign chain_item[0].num = in_tdata[cpfv_pkg::NUM_W-1:0];
  assign chain_item[0].bcd = '0;

  // cell k shifts in binary bit NUM_W-1-k, MSB first
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    cpfv_dd_cell #(
      .BIT_POS(NCELL - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .valid_i(chain_v[k]),
      .item_i (chain_item[k]),
      .valid_o(chain_v[k+1]),
      .item_o (chain_item[k+1])
    );
  end

  cpfv_check u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .valid_i(chain_v[NCELL]),
    .item_i (chain_item[NCELL]),
    .valid_o(res_v),
    .res_o  (res)
  );

  assign push = res_v && adv;

  always_comb begin
    out_v_nxt   = out_v_r;
    out_res_nxt = out_res_r;
    skid_v_nxt  = skid_v_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt   = 1'b1;
        out_res_nxt = skid_res_r;
        skid_v_nxt  = 1'b0;
      end else begin
        out_v_nxt   = push;
        out_res_nxt = res;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (push && out_v_r && !out_tready) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_res_r};

  // skid holds an item only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid full while output empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready && res_v))
    else $error("skid filled without a stalled output");

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_res_r.first_check <= 4'd9) && (out_res_r.second_check <= 4'd9))
    else $error("check digit out of decimal range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_res_r.is_valid) |-> (out_res_r.stored_number == '0))
    else $error("invalid item with nonzero stored number");

endmodule
